[rtl/aysx_pkg.sv]
package aysx_pkg;

  // Field widths of one box and of one result.
  localparam int LOCAL_W = 21;
  localparam int PLACE_W = 22;
  localparam int YAW_W   = 16;
  localparam int SCALE_W = 17;
  localparam int WXZ_W   = 21;
  localparam int WY_W    = 20;

  // Trig format: sine and cosine in signed Q2.30.
  localparam int TRIG_FRAC_BITS = 30;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int ROM_SHIFT      = 62 - TRIG_FRAC_BITS;

  // Rotated coordinate before scaling, and its integer part.
  localparam int T_W  = LOCAL_W + TRIG_W;
  localparam int TH_W = T_W - TRIG_FRAC_BITS;
  localparam int THS_W = TH_W + SCALE_W + 1;
  localparam int TLS_W = TRIG_FRAC_BITS + SCALE_W;
  localparam int P_W   = THS_W + 1;

  // Placement window and rejection limits.
  localparam int COORD_LIMIT = 1000000;
  localparam int SCALE_MAX   = 100000;

  // Floor division by 1000 is done as a shift by three and a multiply by
  // the reciprocal of 125. The scaled value is clamped to 33 signed bits
  // first; anything beyond that is rejected regardless of the exact value.
  localparam int                  PU_W        = 34;
  localparam logic [PU_W-1:0]     POS_OFFSET  = 34'd8388608000;
  localparam int                  OFFSET_Q    = 8388608;
  localparam logic signed [P_W-1:0] P_CLAMP_HI = P_W'(64'sd4294967295);
  localparam logic signed [P_W-1:0] P_CLAMP_LO = P_W'(-64'sd4294967296);
  localparam int                  DIV_X_W     = PU_W - 3;
  localparam logic [31:0]         DIV125_M    = 32'd2199023256;
  localparam int                  DIV125_SH   = 38;
  localparam int                  QM_W        = DIV_X_W + 32;
  localparam int                  Q_W         = QM_W - DIV125_SH;
  localparam int                  FL_W        = 26;

  // Yaw reduction modulo 360: bias to a positive value, then divide by 360
  // as a shift by three and a reciprocal multiply by 45.
  localparam int          YAW_BIAS = 33120;
  localparam int          YU_W     = YAW_W + 1;
  localparam logic [14:0] DIV45_M  = 15'd23302;
  localparam int          DIV45_SH = 20;
  localparam int          ANG_W    = 9;

  // Y path.
  localparam int YP_W = LOCAL_W + SCALE_W + 1;
  localparam int YX_W = 30;
  localparam int YM_W = YX_W + 32;

  localparam int NUM_STAGES = 8;

  typedef logic signed [TRIG_W-1:0]  trig_t;
  typedef logic [TRIG_FRAC_BITS:0]   rom_entry_t;
  typedef rom_entry_t                sine_rom_t [0:90];
  typedef logic [NUM_STAGES:1]       stage_en_t;

  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
  localparam logic [63:0] Q62_ONE = 64'h4000000000000000;

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[125:62];
  endfunction

  function automatic rom_entry_t round_q62(logic [63:0] v);
    logic [63:0] r;
    r = (v + (64'd1 << (ROM_SHIFT - 1))) >> ROM_SHIFT;
    return r[TRIG_FRAC_BITS:0];
  endfunction

  // Sine series term k divides by (2k)(2k+1).
  function automatic logic [63:0] div_sin_den(logic [63:0] v, int k);
    case (k)
      1:       return v / 64'd6;
      2:       return v / 64'd20;
      3:       return v / 64'd42;
      4:       return v / 64'd72;
      5:       return v / 64'd110;
      6:       return v / 64'd156;
      7:       return v / 64'd210;
      8:       return v / 64'd272;
      9:       return v / 64'd342;
      10:      return v / 64'd420;
      11:      return v / 64'd506;
      default: return v / 64'd600;
    endcase
  endfunction

  // Cosine series term k divides by (2k-1)(2k).
  function automatic logic [63:0] div_cos_den(logic [63:0] v, int k);
    case (k)
      1:       return v / 64'd2;
      2:       return v / 64'd12;
      3:       return v / 64'd30;
      4:       return v / 64'd56;
      5:       return v / 64'd90;
      6:       return v / 64'd132;
      7:       return v / 64'd182;
      8:       return v / 64'd240;
      9:       return v / 64'd306;
      10:      return v / 64'd380;
      11:      return v / 64'd462;
      default: return v / 64'd552;
    endcase
  endfunction

  // Sine table for whole degrees 0..90, built at elaboration from Taylor
  // series in Q62. Entries above 45 degrees come from the cosine series.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] step;
    logic [63:0] rest;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] st;
    logic [63:0] ss;
    logic [63:0] ct;
    logic [63:0] cs;
    step = PI_Q62 / 64'd180;
    rest = PI_Q62 % 64'd180;
    for (int d = 0; d <= 45; d++) begin
      x  = step * 64'(d) + (rest * 64'(d)) / 64'd180;
      x2 = mul_q62(x, x);
      st = x;
      ss = x;
      ct = Q62_ONE;
      cs = Q62_ONE;
      for (int k = 1; k <= 12; k++) begin
        st = div_sin_den(mul_q62(st, x2), k);
        ct = div_cos_den(mul_q62(ct, x2), k);
        if (k % 2 == 1) begin
          ss = ss - st;
          cs = cs - ct;
        end else begin
          ss = ss + st;
          cs = cs + ct;
        end
      end
      rom[d] = round_q62(ss);
      if (d < 45) begin
        rom[90 - d] = round_q62(cs);
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Sine of a reduced angle 0..359 by quadrant symmetry.
  function automatic trig_t trig_lookup(logic [ANG_W-1:0] r);
    logic [ANG_W-1:0] idx;
    logic             neg;
    trig_t            mag;
    if (r <= 9'd90) begin
      idx = r;
      neg = 1'b0;
    end else if (r <= 9'd180) begin
      idx = 9'd180 - r;
      neg = 1'b0;
    end else if (r <= 9'd270) begin
      idx = r - 9'd180;
      neg = 1'b1;
    end else begin
      idx = 9'd360 - r;
      neg = 1'b1;
    end
    mag = trig_t'({1'b0, SINE_ROM[idx[6:0]]});
    return neg ? -mag : mag;
  endfunction

endpackage

[rtl/aysx_in_if.sv]
interface aysx_in_if;
  import aysx_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [LOCAL_W-1:0] local_min_x;
  logic signed [LOCAL_W-1:0] local_max_x;
  logic signed [LOCAL_W-1:0] local_min_y;
  logic signed [LOCAL_W-1:0] local_max_y;
  logic signed [LOCAL_W-1:0] local_min_z;
  logic signed [LOCAL_W-1:0] local_max_z;
  logic signed [PLACE_W-1:0] place_x;
  logic signed [PLACE_W-1:0] place_y;
  logic signed [PLACE_W-1:0] place_z;
  logic signed [YAW_W-1:0]   yaw_degrees;
  logic [SCALE_W-1:0]        scale_permille;

  modport source (
    output valid, local_min_x, local_max_x, local_min_y, local_max_y,
           local_min_z, local_max_z, place_x, place_y, place_z,
           yaw_degrees, scale_permille,
    input  ready
  );

  modport sink (
    input  valid, local_min_x, local_max_x, local_min_y, local_max_y,
           local_min_z, local_max_z, place_x, place_y, place_z,
           yaw_degrees, scale_permille,
    output ready
  );

endinterface

[rtl/aysx_out_if.sv]
interface aysx_out_if;
  import aysx_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    status;
  logic signed [WXZ_W-1:0] world_min_x;
  logic signed [WXZ_W-1:0] world_max_x;
  logic [WY_W-1:0]         world_min_y;
  logic [WY_W-1:0]         world_max_y;
  logic signed [WXZ_W-1:0] world_min_z;
  logic signed [WXZ_W-1:0] world_max_z;

  modport source (
    output valid, status, world_min_x, world_max_x, world_min_y, world_max_y,
           world_min_z, world_max_z,
    input  ready
  );

  modport sink (
    input  valid, status, world_min_x, world_max_x, world_min_y, world_max_y,
           world_min_z, world_max_z,
    output ready
  );

endinterface

[rtl/aysx_angle.sv]
module aysx_angle (
  input  logic                               clk,
  input  aysx_pkg::stage_en_t                en,
  input  logic signed [aysx_pkg::YAW_W-1:0]  yaw,
  output aysx_pkg::trig_t                    sin_r,
  output aysx_pkg::trig_t                    cos_r
);
  import aysx_pkg::*;

  logic [YU_W-1:0]   yu;
  logic [28:0]       qprod;
  logic [YU_W-1:0]   yu_r;
  logic [ANG_W-1:0]  yq_r;
  logic [YU_W-1:0]   rem;
  logic [ANG_W-1:0]  ang;
  logic [ANG_W-1:0]  ang_c;

  // Stage 1: quotient of the biased yaw by 360.
  always_comb begin
    yu    = YU_W'(YU_W'(yaw) + YU_W'(YAW_BIAS));
    qprod = 29'(yu[YU_W-1:3]) * 29'(DIV45_M);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      yu_r <= yu;
      yq_r <= qprod[DIV45_SH +: ANG_W];
    end
  end

  // Stage 2: remainder, then sine and cosine from the table.
  always_comb begin
    rem   = yu_r - YU_W'(yq_r) * YU_W'(360);
    ang   = rem[ANG_W-1:0];
    ang_c = (ang >= 9'd270) ? ang - 9'd270 : ang + 9'd90;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sin_r <= trig_lookup(ang);
      cos_r <= trig_lookup(ang_c);
    end
  end

endmodule

[rtl/aysx_yscale.sv]
module aysx_yscale (
  input  logic                                 clk,
  input  aysx_pkg::stage_en_t                  en,
  input  logic signed [aysx_pkg::LOCAL_W-1:0]  local_y,
  input  logic signed [aysx_pkg::PLACE_W-1:0]  place_y,
  input  logic [aysx_pkg::SCALE_W-1:0]         scale,
  output logic signed [aysx_pkg::FL_W-1:0]     world_y_r
);
  import aysx_pkg::*;

  logic signed [YP_W-1:0]    yp_r;
  logic signed [PLACE_W-1:0] py1_r;
  logic signed [PLACE_W-1:0] py2_r;
  logic signed [PLACE_W-1:0] py3_r;
  logic [YP_W-1:0]           mag;
  logic [YX_W-1:0]           yx_r;
  logic                      neg2_r;
  logic                      neg3_r;
  logic [YM_W-1:0]           ym_r;
  logic signed [FL_W-1:0]    yq;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      yp_r  <= YP_W'(local_y) * YP_W'($signed({1'b0, scale}));
      py1_r <= place_y;
    end
  end

  // Truncation toward zero works on the magnitude. Magnitudes beyond 33
  // bits are clamped; they land far outside the accepted window anyway.
  always_comb begin
    mag = yp_r[YP_W-1] ? YP_W'(-yp_r) : YP_W'(yp_r);
    if (mag > YP_W'(64'h1FFFFFFFF)) begin
      mag = YP_W'(64'h1FFFFFFFF);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      yx_r   <= mag[YX_W+2:3];
      neg2_r <= yp_r[YP_W-1];
      py2_r  <= py1_r;
    end
    if (en[3]) begin
      ym_r   <= YM_W'(yx_r) * YM_W'(DIV125_M);
      neg3_r <= neg2_r;
      py3_r  <= py2_r;
    end
  end

  assign yq = FL_W'(ym_r[YM_W-1:DIV125_SH]);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      world_y_r <= neg3_r ? FL_W'(py3_r) - yq : FL_W'(py3_r) + yq;
    end
  end

endmodule

[rtl/aysx_corner.sv]
module aysx_corner (
  input  logic                                 clk,
  input  aysx_pkg::stage_en_t                  en,
  input  logic signed [aysx_pkg::T_W-1:0]      t,
  input  logic [aysx_pkg::SCALE_W-1:0]         scale,
  input  logic signed [aysx_pkg::PLACE_W-1:0]  base,
  output logic signed [aysx_pkg::FL_W-1:0]     fl_r,
  output logic signed [aysx_pkg::FL_W-1:0]     ce_r
);
  import aysx_pkg::*;

  logic signed [TH_W-1:0]    th;
  logic [TRIG_FRAC_BITS-1:0] tl;
  logic signed [THS_W-1:0]   ths_r;
  logic [TLS_W-1:0]          tls_r;
  logic signed [PLACE_W-1:0] base4_r;
  logic signed [PLACE_W-1:0] base5_r;
  logic signed [PLACE_W-1:0] base6_r;
  logic signed [P_W-1:0]     p;
  logic signed [P_W-1:0]     pc;
  logic [PU_W-1:0]           pu;
  logic [PU_W-1:0]           pu5_r;
  logic [PU_W-1:0]           pu6_r;
  logic                      r1_5_r;
  logic                      r1_6_r;
  logic [QM_W-1:0]           qm_r;
  logic [Q_W-1:0]            q;
  logic [PU_W-1:0]           rem;
  logic signed [FL_W-1:0]    fl;
  logic                      inexact;

  // Split into the floor integer part and the fraction so that each
  // product with the scale stays narrow.
  assign th = t[T_W-1:TRIG_FRAC_BITS];
  assign tl = t[TRIG_FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ths_r   <= THS_W'(th) * THS_W'($signed({1'b0, scale}));
      tls_r   <= TLS_W'(tl) * TLS_W'(scale);
      base4_r <= base;
    end
  end

  always_comb begin
    p = P_W'(ths_r) + P_W'($signed({1'b0, tls_r[TLS_W-1:TRIG_FRAC_BITS]}));
    if (p > P_CLAMP_HI) begin
      pc = P_CLAMP_HI;
    end else if (p < P_CLAMP_LO) begin
      pc = P_CLAMP_LO;
    end else begin
      pc = p;
    end
    pu = PU_W'(pc) + POS_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pu5_r   <= pu;
      r1_5_r  <= (tls_r[TRIG_FRAC_BITS-1:0] != '0);
      base5_r <= base4_r;
    end
    if (en[6]) begin
      qm_r    <= QM_W'(pu5_r[PU_W-1:3]) * QM_W'(DIV125_M);
      pu6_r   <= pu5_r;
      r1_6_r  <= r1_5_r;
      base6_r <= base5_r;
    end
  end

  always_comb begin
    q       = qm_r[QM_W-1:DIV125_SH];
    rem     = pu6_r - PU_W'(q) * PU_W'(1000);
    inexact = r1_6_r || (rem != '0);
    fl      = FL_W'(base6_r) + FL_W'($signed({1'b0, q})) - FL_W'(OFFSET_Q);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      fl_r <= fl;
      ce_r <= fl + FL_W'(inexact);
    end
  end

endmodule

[rtl/aabb_yaw_scale_transform_core.sv]
// Places an axis-aligned box: the x/z footprint is rotated by a yaw in whole
// degrees (reduced modulo 360, sine and cosine from a 91-entry Q2.30 table),
// scaled by scale_permille/1000 and offset by the placement; x/z results are
// the floor of the minimum and ceiling of the maximum over the four corners,
// y extents are scaled with truncation toward zero. A box with a scale
// outside 1..100000 or any result outside the +-1000000 window (y: 0..1000000)
// comes out with status 1 and all extents zero. The datapath is an
// eight-stage pipeline that takes one box per cycle while the output side
// keeps up; a result is presented from the last stage's registers and
// leaves when out_chan.ready is high. Each stage
// holds its word until the next stage frees up, so in_chan.ready follows
// out_chan.ready combinationally through the chain of stage valid bits and
// empty stages are filled even while a finished word waits at the output.
module aabb_yaw_scale_transform_core (
  input logic       clk,
  input logic       rst_n,
  aysx_in_if.sink   in_chan,
  aysx_out_if.source out_chan
);
  import aysx_pkg::*;

  stage_en_t                 en;
  logic [NUM_STAGES:1]       v_r;

  logic signed [LOCAL_W-1:0] lx1_r [2];
  logic signed [LOCAL_W-1:0] lz1_r [2];
  logic signed [LOCAL_W-1:0] lx2_r [2];
  logic signed [LOCAL_W-1:0] lz2_r [2];
  logic signed [PLACE_W-1:0] px1_r, pz1_r, px2_r, pz2_r, px3_r, pz3_r;
  logic [SCALE_W-1:0]        sc1_r, sc2_r, sc3_r;
  logic [NUM_STAGES-1:1]     sok_r;

  trig_t                     sin_r;
  trig_t                     cos_r;
  logic signed [T_W-1:0]     tx_r [4];
  logic signed [T_W-1:0]     tz_r [4];
  logic signed [FL_W-1:0]    flx [4];
  logic signed [FL_W-1:0]    cex [4];
  logic signed [FL_W-1:0]    flz [4];
  logic signed [FL_W-1:0]    cez [4];

  logic signed [FL_W-1:0]    y0_4, y1_4;
  logic signed [FL_W-1:0]    y0_5_r, y1_5_r, y0_6_r, y1_6_r, y0_7_r, y1_7_r;

  logic signed [FL_W-1:0]    min_x, max_x, min_z, max_z;
  logic                      bad;

  logic                      status_r;
  logic signed [WXZ_W-1:0]   wmin_x_r, wmax_x_r, wmin_z_r, wmax_z_r;
  logic [WY_W-1:0]           wmin_y_r, wmax_y_r;

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[NUM_STAGES] = !v_r[NUM_STAGES] || out_chan.ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_chan.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_chan.valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Payload that rides along beside the arithmetic units.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      lx1_r[0] <= in_chan.local_min_x;
      lx1_r[1] <= in_chan.local_max_x;
      lz1_r[0] <= in_chan.local_min_z;
      lz1_r[1] <= in_chan.local_max_z;
      px1_r    <= in_chan.place_x;
      pz1_r    <= in_chan.place_z;
      sc1_r    <= in_chan.scale_permille;
      sok_r[1] <= (in_chan.scale_permille != '0) &&
                  (in_chan.scale_permille <= SCALE_W'(SCALE_MAX));
    end
    if (en[2]) begin
      lx2_r <= lx1_r;
      lz2_r <= lz1_r;
      px2_r <= px1_r;
      pz2_r <= pz1_r;
      sc2_r <= sc1_r;
    end
    if (en[3]) begin
      px3_r <= px2_r;
      pz3_r <= pz2_r;
      sc3_r <= sc2_r;
    end
    if (en[5]) begin
      y0_5_r <= y0_4;
      y1_5_r <= y1_4;
    end
    if (en[6]) begin
      y0_6_r <= y0_5_r;
      y1_6_r <= y1_5_r;
    end
    if (en[7]) begin
      y0_7_r <= y0_6_r;
      y1_7_r <= y1_6_r;
    end
    for (int k = 2; k <= NUM_STAGES - 1; k++) begin
      if (en[k]) begin
        sok_r[k] <= sok_r[k-1];
      end
    end
  end

  aysx_angle u_angle (
    .clk   (clk),
    .en    (en),
    .yaw   (in_chan.yaw_degrees),
    .sin_r (sin_r),
    .cos_r (cos_r)
  );

  aysx_yscale u_ymin (
    .clk       (clk),
    .en        (en),
    .local_y   (in_chan.local_min_y),
    .place_y   (in_chan.place_y),
    .scale     (in_chan.scale_permille),
    .world_y_r (y0_4)
  );

  aysx_yscale u_ymax (
    .clk       (clk),
    .en        (en),
    .local_y   (in_chan.local_max_y),
    .place_y   (in_chan.place_y),
    .scale     (in_chan.scale_permille),
    .world_y_r (y1_4)
  );

  // Stage 3: rotate the four corners. Corner i takes x from bit 0 of i and
  // z from bit 1.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        tx_r[i] <= T_W'(lx2_r[i % 2]) * T_W'(cos_r) + T_W'(lz2_r[i / 2]) * T_W'(sin_r);
        tz_r[i] <= T_W'(lz2_r[i / 2]) * T_W'(cos_r) - T_W'(lx2_r[i % 2]) * T_W'(sin_r);
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_corner
    aysx_corner u_cx (
      .clk   (clk),
      .en    (en),
      .t     (tx_r[i]),
      .scale (sc3_r),
      .base  (px3_r),
      .fl_r  (flx[i]),
      .ce_r  (cex[i])
    );
    aysx_corner u_cz (
      .clk   (clk),
      .en    (en),
      .t     (tz_r[i]),
      .scale (sc3_r),
      .base  (pz3_r),
      .fl_r  (flz[i]),
      .ce_r  (cez[i])
    );
  end

  // Stage 8: extremes over the corners and the window check.
  always_comb begin
    min_x = flx[0];
    max_x = cex[0];
    min_z = flz[0];
    max_z = cez[0];
    for (int i = 1; i < 4; i++) begin
      if (flx[i] < min_x) min_x = flx[i];
      if (cex[i] > max_x) max_x = cex[i];
      if (flz[i] < min_z) min_z = flz[i];
      if (cez[i] > max_z) max_z = cez[i];
    end
    bad = !sok_r[NUM_STAGES-1] ||
          (min_x < -FL_W'(COORD_LIMIT)) || (max_x > FL_W'(COORD_LIMIT)) ||
          (min_z < -FL_W'(COORD_LIMIT)) || (max_z > FL_W'(COORD_LIMIT)) ||
          (y0_7_r < 0) || (y0_7_r > FL_W'(COORD_LIMIT)) ||
          (y1_7_r < 0) || (y1_7_r > FL_W'(COORD_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES]) begin
      status_r <= bad;
      wmin_x_r <= bad ? '0 : WXZ_W'(min_x);
      wmax_x_r <= bad ? '0 : WXZ_W'(max_x);
      wmin_z_r <= bad ? '0 : WXZ_W'(min_z);
      wmax_z_r <= bad ? '0 : WXZ_W'(max_z);
      wmin_y_r <= bad ? '0 : WY_W'(y0_7_r);
      wmax_y_r <= bad ? '0 : WY_W'(y1_7_r);
    end
  end

  assign out_chan.valid       = v_r[NUM_STAGES];
  assign out_chan.status      = status_r;
  assign out_chan.world_min_x = wmin_x_r;
  assign out_chan.world_max_x = wmax_x_r;
  assign out_chan.world_min_y = wmin_y_r;
  assign out_chan.world_max_y = wmax_y_r;
  assign out_chan.world_min_z = wmin_z_r;
  assign out_chan.world_max_z = wmax_z_r;

`ifndef NO_ASSERTIONS
  // The input side only stalls when the first stage holds a word.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> v_r[1])
    else $error("input stalled with an empty first stage");

  // A zero scale must be flagged as soon as the box enters.
  a_scale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && (in_chan.scale_permille == '0) |=> !sok_r[1])
    else $error("zero scale not flagged");

  // Floor of every corner is at most its ceiling, so accepted extents are ordered.
  a_xz_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.status |->
      (out_chan.world_min_x <= out_chan.world_max_x) &&
      (out_chan.world_min_z <= out_chan.world_max_z))
    else $error("accepted box has inverted x or z extents");

  // A rejected box carries no extents.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status |->
      (out_chan.world_min_x == '0) && (out_chan.world_max_x == '0) &&
      (out_chan.world_min_y == '0) && (out_chan.world_max_y == '0) &&
      (out_chan.world_min_z == '0) && (out_chan.world_max_z == '0))
    else $error("rejected box has nonzero extents");
`endif

endmodule
